// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  localparam int unsigned LEN_W  = 63;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KEY_W  = 32;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_BAD_OP  = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  // Header byte codes.
  localparam logic [6:0] OPCODE_TEXT = 7'h01;
  localparam logic [6:0] LEN_EXT16   = 7'h7E;
  localparam logic [6:0] LEN_EXT64   = 7'h7F;

  // Remaining header bytes minus one for each extended length form and the mask key.
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_frame;
    logic              final_fragment;
    logic [LEN_W-1:0]  frame_len;
  } wsd_result_t;

endpackage

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [7:0]                 rx_byte,
  output wsd_pkg::wsd_result_t       res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              fin_r, fin_nxt;
  logic              mask_on_r, mask_on_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [2:0]        hcnt_r, hcnt_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [1:0]        kidx_r, kidx_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;

  logic              hdr_done;
  logic [1:0]        kind;
  logic [7:0]        data;
  logic              last;
  logic [7:0]        key_byte;

  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    mask_on_nxt = mask_on_r;
    len_nxt     = len_r;
    hcnt_nxt    = hcnt_r;
    key_nxt     = key_r;
    kidx_nxt    = kidx_r;
    left_nxt    = left_r;
    hdr_done    = 1'b0;
    kind        = KIND_HEADER;
    data        = '0;
    last        = 1'b0;
    key_byte    = '0;

    unique case (phase_r)
      PH_HDR1: begin
        mask_on_nxt = rx_byte[7];
        if (rx_byte[6:0] == LEN_EXT16) begin
          hcnt_nxt  = EXT16_CNT;
          len_nxt   = '0;
          phase_nxt = PH_EXTLEN;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          hcnt_nxt  = EXT64_CNT;
          len_nxt   = '0;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt  = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
          hdr_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        // Big-endian accumulation; the top bit of a 64-bit length falls off.
        len_nxt = {len_r[LEN_W-9:0], rx_byte};
        if (hcnt_r == 3'd0) begin
          hdr_done = 1'b1;
        end else begin
          hcnt_nxt = hcnt_r - 3'd1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[KEY_W-9:0], rx_byte};
        if (hcnt_r == 3'd0) begin
          if (len_r == '0) begin
            phase_nxt = PH_HDR0;
            last      = 1'b1;
            kind      = KIND_EMPTY;
          end else begin
            left_nxt  = len_r;
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          hcnt_nxt = hcnt_r - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        if (mask_on_r) begin
          unique case (kidx_r)
            2'd0:    key_byte = key_r[31:24];
            2'd1:    key_byte = key_r[23:16];
            2'd2:    key_byte = key_r[15:8];
            default: key_byte = key_r[7:0];
          endcase
        end
        data     = rx_byte ^ key_byte;
        kidx_nxt = kidx_r + 2'd1;
        kind     = KIND_PAYLOAD;
        if (left_r != '0) begin
          left_nxt = left_r - {{(LEN_W-1){1'b0}}, 1'b1};
        end
        // The count reaches zero when it was one or already zero.
        if (left_r[LEN_W-1:1] == '0) begin
          last      = 1'b1;
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        phase_nxt   = PH_HDR0;
        fin_nxt     = rx_byte[7];
        len_nxt     = '0;
        mask_on_nxt = 1'b0;
        key_nxt     = '0;
        kidx_nxt    = '0;
        left_nxt    = '0;
        hcnt_nxt    = '0;
        if (rx_byte[6:0] != OPCODE_TEXT) begin
          kind = KIND_BAD_OP;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
    endcase

    if (hdr_done) begin
      if (mask_on_nxt) begin
        phase_nxt = PH_MASK;
        hcnt_nxt  = KEY_CNT;
      end else if (len_nxt == '0) begin
        phase_nxt = PH_HDR0;
        last      = 1'b1;
        kind      = KIND_EMPTY;
      end else begin
        left_nxt  = len_nxt;
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  assign res.kind           = kind;
  assign res.data_byte      = data;
  assign res.last_of_frame  = last;
  assign res.final_fragment = fin_nxt;
  assign res.frame_len      = len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      fin_r     <= 1'b0;
      mask_on_r <= 1'b0;
      len_r     <= '0;
      hcnt_r    <= '0;
      key_r     <= '0;
      kidx_r    <= '0;
      left_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      mask_on_r <= mask_on_nxt;
      len_r     <= len_nxt;
      hcnt_r    <= hcnt_nxt;
      key_r     <= key_nxt;
      kidx_r    <= kidx_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

// ===== rtl/wsd_out_buf.sv =====
module wsd_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wsd_pkg::wsd_result_t  push_data,
  output logic                  has_room,
  output logic                  head_valid,
  input  logic                  pop,
  output wsd_pkg::wsd_result_t  head
);
  import wsd_pkg::*;

  // Two-entry buffer: a full-rate stream keeps flowing and a stall on the
  // result side reaches the input side through has_room, taken from count_r.
  wsd_result_t slot0_r, slot0_nxt;
  wsd_result_t slot1_r, slot1_nxt;
  logic [1:0]  count_r, count_nxt;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          slot0_nxt = push_data;
        end else begin
          slot1_nxt = push_data;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          slot0_nxt = push_data;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign has_room   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slot0_r;

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Channel  | Ports                                   | Moves
// in       | in_valid, in_ready, in_rx_byte          | one stream byte per word
// out      | out_valid, out_ready, out_kind, ...     | one result word per byte
//
// Every accepted byte yields exactly one result word, which is held in the
// result buffer and offered once older words on the result side have gone.
// Throughput is one byte per clock while in_ready is high; the parser state
// updates in the cycle a byte is taken. Reset clears the parser to wait for
// a first header byte and empties the two-entry result buffer. A stall on
// out_ready drops in_ready once both buffer entries are occupied.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last_of_frame,
  output logic        out_final_fragment,
  output logic [62:0] out_frame_len
);
  import wsd_pkg::*;

  logic        step;
  logic        room;
  wsd_result_t res;
  wsd_result_t head;

  assign in_ready = room;
  assign step     = in_valid & room;

  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  wsd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .push_data  (res),
    .has_room   (room),
    .head_valid (out_valid),
    .pop        (out_valid & out_ready),
    .head       (head)
  );

  assign out_kind           = head.kind;
  assign out_data_byte      = head.data_byte;
  assign out_last_of_frame  = head.last_of_frame;
  assign out_final_fragment = head.final_fragment;
  assign out_frame_len      = head.frame_len;

endmodule

// ===== tb/tb_websocket_frame_deframer.sv =====
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    WAIT_FIRST,
    WAIT_SECOND,
    EXT_LEN,
    MASK_KEY,
    PAYLOAD
  } parse_phase_t;

  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_last_of_frame;
  logic        out_final_fragment;
  logic [62:0] out_frame_len;

  websocket_frame_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_last_of_frame  (out_last_of_frame),
    .out_final_fragment (out_final_fragment),
    .out_frame_len      (out_frame_len)
  );

  always #5 clk = ~clk;

  // Parser state mirrored by the predictor.
  parse_phase_t     prs_phase = WAIT_FIRST;
  logic             prs_fin = 1'b0;
  logic             prs_masked = 1'b0;
  logic [LEN_W-1:0] prs_len = '0;
  logic [2:0]       prs_hdr_cnt = '0;
  logic [KEY_W-1:0] prs_key = '0;
  logic [1:0]       prs_key_idx = '0;
  logic [LEN_W-1:0] prs_left = '0;

  wsd_result_t predicted_results[$];

  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int bad_sent = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  bit in_gaps = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void begin_payload(inout wsd_result_t r);
    if (prs_len == '0) begin
      prs_phase = WAIT_FIRST;
      r.last_of_frame = 1'b1;
      r.kind = KIND_EMPTY;
    end else begin
      prs_left = prs_len;
      prs_phase = PAYLOAD;
    end
  endfunction

  function automatic void header_complete(inout wsd_result_t r);
    if (prs_masked) begin
      prs_phase = MASK_KEY;
      prs_hdr_cnt = KEY_CNT;
    end else begin
      begin_payload(r);
    end
  endfunction

  // Advances the mirrored parser by one byte and queues the word it yields.
  function automatic void deframe_byte(input logic [7:0] b);
    wsd_result_t r;
    logic [7:0]  key_byte;
    r = '0;
    r.kind = KIND_HEADER;
    case (prs_phase)
      WAIT_SECOND: begin
        prs_masked = b[7];
        if (b[6:0] == LEN_EXT16) begin
          prs_hdr_cnt = EXT16_CNT;
          prs_len = '0;
          prs_phase = EXT_LEN;
        end else if (b[6:0] == LEN_EXT64) begin
          prs_hdr_cnt = EXT64_CNT;
          prs_len = '0;
          prs_phase = EXT_LEN;
        end else begin
          prs_len = {56'd0, b[6:0]};
          header_complete(r);
        end
      end
      EXT_LEN: begin
        // Shifting out the top byte keeps the length at 63 bits.
        prs_len = {prs_len[LEN_W-9:0], b};
        if (prs_hdr_cnt == '0) header_complete(r);
        else prs_hdr_cnt = prs_hdr_cnt - 3'd1;
      end
      MASK_KEY: begin
        prs_key = {prs_key[KEY_W-9:0], b};
        if (prs_hdr_cnt == '0) begin_payload(r);
        else prs_hdr_cnt = prs_hdr_cnt - 3'd1;
      end
      PAYLOAD: begin
        key_byte = prs_masked ? prs_key[8*(3-prs_key_idx) +: 8] : 8'h00;
        r.data_byte = b ^ key_byte;
        prs_key_idx = prs_key_idx + 2'd1;
        r.kind = KIND_PAYLOAD;
        if (prs_left != '0) prs_left = prs_left - 63'd1;
        if (prs_left == '0) begin
          r.last_of_frame = 1'b1;
          prs_phase = WAIT_FIRST;
        end
      end
      default: begin
        prs_phase = WAIT_FIRST;
        prs_fin = b[7];
        prs_len = '0;
        prs_masked = 1'b0;
        prs_key = '0;
        prs_key_idx = '0;
        prs_left = '0;
        prs_hdr_cnt = '0;
        if (b[6:0] != OPCODE_TEXT) r.kind = KIND_BAD_OP;
        else prs_phase = WAIT_SECOND;
      end
    endcase
    r.final_fragment = prs_fin;
    r.frame_len = prs_len;
    predicted_results.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (in_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Sends a text frame; n_payload may fall short of len to leave a frame open.
  task automatic send_frame(input bit fin, input bit masked, input int form,
                            input logic [62:0] len, input int n_payload,
                            input bit top_bit);
    logic [63:0] ext;
    logic [31:0] key;
    key = $urandom;
    ext = {top_bit, len};
    send_byte({fin, OPCODE_TEXT});
    case (form)
      FORM_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(ext[8*i +: 8]);
      end
      default: begin
        send_byte({masked, len[6:0]});
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (int i = 0; i < n_payload; i++) send_byte(8'($urandom));
    frames_sent++;
  endtask

  task automatic send_bad_first(input logic [7:0] b);
    send_byte(b);
    bad_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_bad_opcodes();
    send_bad_first(8'h00);
    send_bad_first(8'hFF);
    send_bad_first(8'h41);
  endtask

  task automatic test_directed_frames();
    send_frame(1'b1, 1'b0, FORM_SHORT, 63'd0, 0, 1'b0);
    // Five masked bytes wrap the key index back to the first key byte.
    send_frame(1'b0, 1'b1, FORM_SHORT, 63'd5, 5, 1'b0);
    // The top bit of the 64-bit length must be ignored.
    send_frame(1'b1, 1'b0, FORM_EXT64, 63'd1, 1, 1'b1);
    // Zero length ends the frame on the last mask key byte.
    send_frame(1'b1, 1'b1, FORM_EXT16, 63'd0, 0, 1'b0);
    drain_results();
  endtask

  task automatic test_random_frames(input int n_bytes);
    int          form;
    int          r;
    logic [62:0] len;
    logic [7:0]  b;
    while (bytes_sent < n_bytes) begin
      if (frames_sent % 40 == 0) begin
        in_gaps = $urandom_range(0, 2) != 0;
        stall_on = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom); while (b[6:0] == OPCODE_TEXT);
          send_bad_first(b);
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          form = FORM_SHORT;
          r = $urandom_range(0, 99);
          if (r < 60) len = 63'($urandom_range(0, 8));
          else if (r < 90) len = 63'($urandom_range(9, 40));
          else len = 63'($urandom_range(41, 125));
        end else if (r < 90) begin
          form = FORM_EXT16;
          len = ($urandom_range(0, 9) == 0) ? 63'($urandom_range(0, 300))
                                            : 63'($urandom_range(0, 12));
        end else begin
          form = FORM_EXT64;
          len = 63'($urandom_range(0, 40));
        end
        send_frame(1'($urandom), 1'($urandom), form, len, int'(len), 1'($urandom));
      end
      if ($urandom_range(0, 29) == 0) drain_results();
    end
    drain_results();
  endtask

  // A masked frame with the largest length; it is still open when the run ends.
  task automatic test_long_frame();
    in_gaps = 1'b1;
    stall_on = 1'b1;
    send_frame(1'b1, 1'b1, FORM_EXT64, '1, 60, 1'b1);
    drain_results();
  endtask

  always @(negedge clk) begin
    if (!rst_n || !stall_on) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    wsd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("result word with none expected: kind %0d", out_kind);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        kind_seen[want.kind]++;
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          errors++;
        end
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, actual %0h", want.data_byte, out_data_byte);
          errors++;
        end
        if (out_last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0d, actual %0d",
                 want.last_of_frame, out_last_of_frame);
          errors++;
        end
        if (out_final_fragment !== want.final_fragment) begin
          $error("final_fragment: expected %0d, actual %0d",
                 want.final_fragment, out_final_fragment);
          errors++;
        end
        if (out_frame_len !== want.frame_len) begin
          $error("frame_len: expected %0h, actual %0h",
                 want.frame_len, out_frame_len);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_bad_opcodes();
    test_directed_frames();
    test_random_frames(1580);
    test_long_frame();

    repeat (20) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d result words never arrived", predicted_results.size());
      errors++;
    end
    $display("Sent %0d bytes: %0d text frames and %0d rejected first bytes.",
             bytes_sent, frames_sent, bad_sent);
    $display("Checked %0d header, %0d payload, %0d bad opcode and %0d empty frame words.",
             kind_seen[KIND_HEADER], kind_seen[KIND_PAYLOAD],
             kind_seen[KIND_BAD_OP], kind_seen[KIND_EMPTY]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
